@@ sv/per_source_rate_blocker_top_assert.svh @@
// assertion macros used by the port checker file
// no dependencies
`ifndef PER_SOURCE_RATE_BLOCKER_TOP_ASSERT_SVH
`define PER_SOURCE_RATE_BLOCKER_TOP_ASSERT_SVH
`define PSRB_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lbl failed");
`define PSRB_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lbl failed");
`endif

@@ sv/psrb_pkg.sv @@
// shared constants and types of the per-source rate blocker
// no dependencies
package psrb_pkg;
  localparam int FlowEntries = 16;
  localparam int BlockEntries = 16;
  localparam int FlowIdxW = $clog2(FlowEntries);
  localparam int BlockIdxW = (BlockEntries > 1) ? $clog2(BlockEntries) : 1;
  localparam int QueueDepth = 2;
  localparam logic [15:0] ThresholdReset = 16'd1000;
  localparam logic [15:0] CountMax = 16'hffff;
  localparam logic ActPacket = 1'b0;
  localparam logic ActWindowEnd = 1'b1;
  localparam logic [0:0] RegAlertThreshold = 1'b0;

  typedef struct packed {
    logic        action;
    logic [31:0] addr;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } scan_state_t;
endpackage

@@ sv/per_source_rate_blocker_top.sv @@
// per-source rate blocker: packet counts per source, scans at window end
// a packet beat is queued, then counted in the flow table; it gives no result
// a window-end beat is queued, then scans every flow entry and reports those over threshold
// throughput: one packet per cycle while busy is low; a window end holds busy until the scan ends
// reset (synchronous rst_n): flow table, block list and overflow flag cleared
// threshold returns to 1000; the receiver cannot stall results
module per_source_rate_blocker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_source_address,
  output logic        out_strobe,
  output logic [31:0] out_flagged_address,
  output logic [15:0] out_flagged_count,
  output logic        out_was_blocked,
  output logic        out_block_list_full,
  output logic        out_table_overflowed,
  output logic        out_last_report,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psrb_pkg::*;

  // alert threshold register at byte address 0
  logic [15:0] cfg_threshold_r;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegAlertThreshold);
  assign prdata = (paddr[2] == RegAlertThreshold) ? {16'd0, cfg_threshold_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_threshold_r <= ThresholdReset;
    else if (cfg_wr) cfg_threshold_r <= pwdata[15:0];
  end

  cmd_t cmd, q_head;
  logic q_valid, q_pop;
  assign cmd = '{action: in_action, addr: in_source_address};

  // front queue decouples command beats from table work
  psrb_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  // back runs packet counts and the window scan
  psrb_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .threshold(cfg_threshold_r), .out_strobe(out_strobe),
    .out_flagged_address(out_flagged_address), .out_flagged_count(out_flagged_count),
    .out_was_blocked(out_was_blocked), .out_block_list_full(out_block_list_full),
    .out_table_overflowed(out_table_overflowed), .out_last_report(out_last_report)
  );
endmodule

@@ sv/psrb_front.sv @@
// front part: takes commands into a short queue
// depends on psrb_pkg
module psrb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  psrb_pkg::cmd_t  cmd_in,
  output logic            q_valid,
  output psrb_pkg::cmd_t  q_head,
  input  logic            q_pop
);
  import psrb_pkg::*;

  cmd_t q_r [QueueDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic push;
  logic push_head;

  // stop taking after a window end until the back has finished
  logic hold_r, hold_nxt;

  assign busy = hold_r || (cnt_r == 2'(QueueDepth));
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head = q_r[0];
  // new beat lands at the head when the queue is empty after this edge's pop
  assign push_head = push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && q_pop));

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    hold_nxt = hold_r;
    if (push && cmd_in.action == ActWindowEnd) hold_nxt = 1'b1;
    if (q_pop && q_r[0].action == ActWindowEnd) hold_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      hold_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_head) q_r[0] <= cmd_in;
    else if (q_pop) q_r[0] <= q_r[1];
    if (push && !push_head) q_r[1] <= cmd_in;
  end
endmodule

@@ sv/psrb_back.sv @@
// back part: flow table, block list and window scan
// depends on psrb_pkg
module psrb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  psrb_pkg::cmd_t  q_head,
  output logic            q_pop,
  input  logic [15:0]     threshold,
  output logic            out_strobe,
  output logic [31:0]     out_flagged_address,
  output logic [15:0]     out_flagged_count,
  output logic            out_was_blocked,
  output logic            out_block_list_full,
  output logic            out_table_overflowed,
  output logic            out_last_report
);
  import psrb_pkg::*;

  logic [31:0] faddr_r [FlowEntries];
  logic [15:0] fcnt_r [FlowEntries];
  logic [FlowEntries-1:0] fvalid_r;
  logic [31:0] baddr_r [BlockEntries];
  logic [BlockEntries-1:0] bvalid_r;
  logic ovf_r;

  scan_state_t st_r, st_nxt;
  logic [FlowIdxW-1:0] idx_r, idx_nxt;

  // pending result waiting for a later flagged entry to know last
  logic        pend_r;
  logic [31:0] pa_r;
  logic [15:0] pc_r;
  logic        pk_r, pf_r;

  logic [FlowEntries-1:0] hit;
  logic [FlowIdxW-1:0] hit_idx, free_idx;
  logic any_hit, any_free;

  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    any_hit = 1'b0;
    any_free = 1'b0;
    for (int i = FlowEntries - 1; i >= 0; i--) begin
      hit[i] = fvalid_r[i] && (faddr_r[i] == q_head.addr);
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = FlowIdxW'(i);
      end
      if (!fvalid_r[i]) begin
        any_free = 1'b1;
        free_idx = FlowIdxW'(i);
      end
    end
  end

  // block list lookup for the scanned entry
  logic flag;
  logic known, bfree;
  logic [BlockIdxW-1:0] bfree_idx;
  assign flag = fvalid_r[idx_r] && (fcnt_r[idx_r] > threshold);
  always_comb begin
    known = 1'b0;
    bfree = 1'b0;
    bfree_idx = '0;
    for (int j = BlockEntries - 1; j >= 0; j--) begin
      if (bvalid_r[j] && baddr_r[j] == faddr_r[idx_r]) known = 1'b1;
      if (!bvalid_r[j]) begin
        bfree = 1'b1;
        bfree_idx = BlockIdxW'(j);
      end
    end
  end

  logic last_idx;
  assign last_idx = (idx_r == FlowIdxW'(FlowEntries - 1));

  // pending result leaves when the next flagged entry shows up or at scan end
  logic emit_mid, emit_last;
  assign emit_mid = (st_r == ST_SCAN) && flag && pend_r;
  assign emit_last = (st_r == ST_REPORT) && pend_r;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    q_pop = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.action == ActPacket) q_pop = 1'b1;
          else begin
            st_nxt = ST_SCAN;
            idx_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + FlowIdxW'(1);
        if (last_idx) st_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        q_pop = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      idx_r <= '0;
      fvalid_r <= '0;
      bvalid_r <= '0;
      ovf_r <= 1'b0;
      pend_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      out_strobe <= emit_mid || emit_last;
      if (st_r == ST_IDLE && q_pop) begin
        if (any_hit) begin
          if (fcnt_r[hit_idx] != CountMax) fcnt_r[hit_idx] <= fcnt_r[hit_idx] + 16'd1;
        end else if (any_free) begin
          fvalid_r[free_idx] <= 1'b1;
          faddr_r[free_idx] <= q_head.addr;
          fcnt_r[free_idx] <= 16'd1;
        end else ovf_r <= 1'b1;
      end
      if (st_r == ST_SCAN && flag) begin
        if (!known && bfree) begin
          bvalid_r[bfree_idx] <= 1'b1;
          baddr_r[bfree_idx] <= faddr_r[idx_r];
        end
        pend_r <= 1'b1;
        pa_r <= faddr_r[idx_r];
        pc_r <= fcnt_r[idx_r];
        pk_r <= known;
        pf_r <= !known && !bfree;
      end
      if (st_r == ST_REPORT) begin
        pend_r <= 1'b0;
        fvalid_r <= '0;
        ovf_r <= 1'b0;
      end
      if (emit_mid || emit_last) begin
        out_flagged_address <= pa_r;
        out_flagged_count <= pc_r;
        out_was_blocked <= pk_r;
        out_block_list_full <= pf_r;
        out_table_overflowed <= ovf_r;
        out_last_report <= emit_last;
      end
    end
  end
endmodule

@@ sv/psrb_checker.sv @@
// port-level assertions for the per-source rate blocker
// depends on per_source_rate_blocker_top_assert.svh
`include "per_source_rate_blocker_top_assert.svh"
module psrb_port_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_strobe,
  input logic out_was_blocked,
  input logic out_block_list_full,
  input logic pready
);
  `PSRB_ASSERT_IMP(a_full_excl, out_strobe, !(out_was_blocked && out_block_list_full))
  `PSRB_ASSERT_NXT(a_we_busy, start && !busy && in_action, busy)
  `PSRB_ASSERT_IMP(a_pready, 1'b1, pready)
endmodule

bind per_source_rate_blocker_top psrb_port_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_action(in_action),
  .out_strobe(out_strobe), .out_was_blocked(out_was_blocked),
  .out_block_list_full(out_block_list_full), .pready(pready)
);

@@ tb/psrb_checker.sv @@
`timescale 1ns / 1ps
// checker for the per-source rate blocker: predicts scan reports and compares
// depends on psrb_pkg for the action codes, table sizes and threshold reset
module psrb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_source_address,
  input  logic        out_strobe,
  input  logic [31:0] out_flagged_address,
  input  logic [15:0] out_flagged_count,
  input  logic        out_was_blocked,
  input  logic        out_block_list_full,
  input  logic        out_table_overflowed,
  input  logic        out_last_report,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import psrb_pkg::*;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] count;
    logic        was_blocked;
    logic        list_full;
    logic        overflowed;
    logic        last;
  } report_t;

  report_t     report_q[$];
  logic [15:0] threshold;
  logic [31:0] flow_addr [FlowEntries];
  logic [15:0] flow_cnt  [FlowEntries];
  logic        flow_val  [FlowEntries];
  logic [31:0] blk_addr  [BlockEntries];
  logic        blk_val   [BlockEntries];
  logic        ovf_seen;

  assign pending = report_q.size();

  // count one packet: hit, allocate lowest free entry, or flag overflow
  task automatic count_packet(input logic [31:0] addr);
    int free_idx;
    free_idx = -1;
    for (int i = 0; i < FlowEntries; i++) begin
      if (flow_val[i] && flow_addr[i] == addr) begin
        if (flow_cnt[i] != CountMax) flow_cnt[i]++;
        return;
      end
      if (!flow_val[i] && free_idx < 0) free_idx = i;
    end
    if (free_idx >= 0) begin
      flow_val[free_idx] = 1'b1;
      flow_addr[free_idx] = addr;
      flow_cnt[free_idx] = 16'd1;
    end else begin
      ovf_seen = 1'b1;
    end
  endtask

  // window end: report every source over threshold, update block list, clear
  task automatic scan_window();
    report_t r;
    int      n;
    int      free_idx;
    logic    known;
    n = 0;
    for (int i = 0; i < FlowEntries; i++) begin
      if (flow_val[i] && flow_cnt[i] > threshold) begin
        known = 1'b0;
        free_idx = -1;
        for (int j = 0; j < BlockEntries; j++) begin
          if (blk_val[j] && blk_addr[j] == flow_addr[i]) known = 1'b1;
          if (!blk_val[j] && free_idx < 0) free_idx = j;
        end
        r.addr = flow_addr[i];
        r.count = flow_cnt[i];
        r.was_blocked = known;
        r.list_full = 1'b0;
        r.overflowed = ovf_seen;
        r.last = 1'b0;
        if (!known) begin
          if (free_idx >= 0) begin
            blk_val[free_idx] = 1'b1;
            blk_addr[free_idx] = flow_addr[i];
          end else begin
            r.list_full = 1'b1;
          end
        end
        report_q.push_back(r);
        n++;
      end
    end
    if (n > 0) report_q[report_q.size() - 1].last = 1'b1;
    for (int i = 0; i < FlowEntries; i++) flow_val[i] = 1'b0;
    ovf_seen = 1'b0;
  endtask

  always @(posedge clk) begin
    report_t exp_r;
    if (!rst_n) begin
      threshold = ThresholdReset;
      for (int i = 0; i < FlowEntries; i++) flow_val[i] = 1'b0;
      for (int j = 0; j < BlockEntries; j++) blk_val[j] = 1'b0;
      ovf_seen = 1'b0;
      report_q.delete();
      fail_count = 0;
    end else begin
      // results first: a beat leaving now belongs to an earlier window end
      if (out_strobe) begin
        if (report_q.size() == 0) begin
          $error("unexpected report beat, address %h", out_flagged_address);
          fail_count++;
        end else begin
          exp_r = report_q.pop_front();
          if (out_flagged_address !== exp_r.addr) begin
            $error("flagged_address expected %h actual %h", exp_r.addr, out_flagged_address);
            fail_count++;
          end
          if (out_flagged_count !== exp_r.count) begin
            $error("flagged_count expected %0d actual %0d", exp_r.count, out_flagged_count);
            fail_count++;
          end
          if (out_was_blocked !== exp_r.was_blocked) begin
            $error("was_blocked expected %b actual %b", exp_r.was_blocked, out_was_blocked);
            fail_count++;
          end
          if (out_block_list_full !== exp_r.list_full) begin
            $error("block_list_full expected %b actual %b", exp_r.list_full,
                   out_block_list_full);
            fail_count++;
          end
          if (out_table_overflowed !== exp_r.overflowed) begin
            $error("table_overflowed expected %b actual %b", exp_r.overflowed,
                   out_table_overflowed);
            fail_count++;
          end
          if (out_last_report !== exp_r.last) begin
            $error("last_report expected %b actual %b", exp_r.last, out_last_report);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == RegAlertThreshold)
        threshold = pwdata[15:0];
      if (start && !busy) begin
        if (in_action == ActWindowEnd) scan_window();
        else count_packet(in_source_address);
      end
    end
  end
endmodule

@@ tb/tb_per_source_rate_blocker_top.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the per-source rate blocker top level
// depends on psrb_pkg, per_source_rate_blocker_top and psrb_checker
module tb_per_source_rate_blocker_top;
  import psrb_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int DrainCycles = FlowEntries + 8;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [31:0] in_source_address;
  logic        out_strobe;
  logic [31:0] out_flagged_address;
  logic [15:0] out_flagged_count;
  logic        out_was_blocked;
  logic        out_block_list_full;
  logic        out_table_overflowed;
  logic        out_last_report;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  int          beats_sent;
  logic [31:0] addr_pool [24];

  per_source_rate_blocker_top DUT (.*);

  psrb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_source_address(in_source_address),
    .out_strobe(out_strobe), .out_flagged_address(out_flagged_address),
    .out_flagged_count(out_flagged_count), .out_was_blocked(out_was_blocked),
    .out_block_list_full(out_block_list_full),
    .out_table_overflowed(out_table_overflowed), .out_last_report(out_last_report),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // watchdog: cycles with no accepted beat, no report and no register write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[per_source_rate_blocker_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat; gap_max of 0 gives back-to-back beats
  task automatic send_beat(input logic act, input logic [31:0] addr, input int gap_max);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_source_address <= addr;
    // busy is settled by the falling edge, the next rising edge takes the beat
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  // register write only while idle: drain reports, then let a silent scan finish
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // random window: mostly repeat sources from the pool so counts climb
  task automatic random_window();
    int len;
    len = $urandom_range(0, 30);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) send_beat(ActPacket, $urandom(), 10);
      else send_beat(ActPacket, addr_pool[$urandom_range(0, 23)], 10);
    end
    send_beat(ActWindowEnd, $urandom(), 10);
  endtask

  initial begin
    logic [15:0] thr_list [6];
    thr_list = '{16'd0, 16'd1, 16'd3, 16'd65535, 16'd2, 16'd5};
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ActPacket;
    in_source_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    beats_sent = 0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default threshold: one packet, nothing flagged
    send_beat(ActPacket, 32'h0000_0000, 3);
    send_beat(ActWindowEnd, 32'hffff_ffff, 3);

    // threshold 0: address extremes, repeat source, then a hit on the block list
    write_reg(3'(RegAlertThreshold) * 3'd4, 32'hffff_0000);
    write_reg(3'd4, 32'h0000_1234);  // unmapped register, ignored
    send_beat(ActPacket, 32'h0000_0000, 3);
    send_beat(ActPacket, 32'hffff_ffff, 3);
    send_beat(ActPacket, 32'hffff_ffff, 0);
    send_beat(ActPacket, 32'h5a5a_a5a5, 0);
    send_beat(ActWindowEnd, 32'h0, 3);
    send_beat(ActPacket, 32'hffff_ffff, 3);
    send_beat(ActWindowEnd, 32'h0, 0);
    // empty window end
    send_beat(ActWindowEnd, 32'h0, 0);

    // flow table overflow and block list running out of slots
    for (int i = 0; i <= FlowEntries; i++) send_beat(ActPacket, 32'h0a00_0100 + i, 2);
    send_beat(ActWindowEnd, 32'h0, 2);
    // overflow that is never reported: nothing over threshold
    write_reg(3'd0, 32'd65535);
    for (int i = 0; i <= FlowEntries; i++) send_beat(ActPacket, 32'hc0a8_0000 + i, 0);
    send_beat(ActWindowEnd, 32'h0, 0);

    // back-to-back packets from one source just over a small threshold
    write_reg(3'd0, 32'd2);
    for (int i = 0; i < 5; i++) send_beat(ActPacket, 32'h0102_0304, 0);
    send_beat(ActWindowEnd, 32'h0, 0);

    // random windows across several thresholds
    for (int p = 0; beats_sent < 360; p++) begin
      write_reg(3'd0, {16'h0, thr_list[p % 6]});
      for (int w = 0; w < 3; w++) random_window();
    end
    start <= 1'b0;

    // drain the reports, then wait quietly before the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[per_source_rate_blocker_top] OK");
    end else begin
      $display("[per_source_rate_blocker_top] ERROR");
    end
    $finish;
  end
endmodule
